// File: sv/colormap_sampler_defines.svh
// Assertion macros shared by the colormap sampler modules.
`ifndef COLORMAP_SAMPLER_DEFINES_SVH
`define COLORMAP_SAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cms_pkg.sv
package cms_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int SEL_W  = 3;
   localparam int CH_W   = 8;
   localparam int RGB_W  = 3 * CH_W;
   localparam int LEVEL_W = 18;
   localparam int REQ_W  = 24;
   localparam int RSP_W  = 24;

   localparam logic [SEL_W-1:0] SEL_HSV = 3'd7;

   localparam int NUM_STOPS  = 35;
   localparam int STOP_IDX_W = 6;
   localparam int POS_W      = 10;
   localparam int MAX_SEGS   = 8;
   localparam int NUM_MAPS   = 8;

   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 13;
   localparam int QP_W        = 19;
   localparam int EST_W       = 9;
   localparam int PROD_W      = QP_W + RECIP_W;
   localparam int REM_W       = QP_W + 1;

   localparam logic [RECIP_W-1:0] RECIP_125  = RECIP_W'((1 << RECIP_SHIFT) / 125);
   localparam logic [RECIP_W-1:0] RECIP_200  = RECIP_W'((1 << RECIP_SHIFT) / 200);
   localparam logic [RECIP_W-1:0] RECIP_250  = RECIP_W'((1 << RECIP_SHIFT) / 250);
   localparam logic [RECIP_W-1:0] RECIP_333  = RECIP_W'((1 << RECIP_SHIFT) / 333);
   localparam logic [RECIP_W-1:0] RECIP_334  = RECIP_W'((1 << RECIP_SHIFT) / 334);
   localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'((1 << RECIP_SHIFT) / 1000);

   typedef enum logic [2:0] {
      SPAN_125  = 3'd0,
      SPAN_200  = 3'd1,
      SPAN_250  = 3'd2,
      SPAN_333  = 3'd3,
      SPAN_334  = 3'd4,
      SPAN_1000 = 3'd5
   } span_type;

   typedef struct packed {
      logic s5_load;
      logic s6_load;
      logic s7_load;
      logic s6_full;
   } cms_adv_type;

   localparam logic [POS_W-1:0] STOP_POS [NUM_STOPS] = '{
      10'd0, 10'd125, 10'd375, 10'd500, 10'd625, 10'd875, 10'd1000,
      10'd0, 10'd200, 10'd400, 10'd600, 10'd800, 10'd1000,
      10'd0, 10'd125, 10'd250, 10'd375, 10'd500, 10'd625, 10'd750, 10'd875, 10'd1000,
      10'd0, 10'd250, 10'd500, 10'd750, 10'd1000,
      10'd0, 10'd333, 10'd666, 10'd1000,
      10'd0, 10'd1000,
      10'd0, 10'd1000
   };

   localparam logic [RGB_W-1:0] STOP_RGB [NUM_STOPS] = '{
      24'h000080, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h800000,
      24'h352A87, 24'h1263DF, 24'h04A3BB, 24'h51BC78, 24'hE5B841, 24'hF9FB0E,
      24'h30123B, 24'h466BE3, 24'h29BFEC, 24'h28E598, 24'h91F642, 24'hE2DE35,
      24'hF99627, 24'hDB421A, 24'h7A0B04,
      24'h440154, 24'h3B528B, 24'h21918C, 24'h5EC961, 24'hFDE725,
      24'h000000, 24'hE60000, 24'hFFE600, 24'hFFFFFF,
      24'h00FFFF, 24'hFF00FF,
      24'h000000, 24'hFFFFFF
   };

   localparam logic [STOP_IDX_W-1:0] MAP_FIRST [NUM_MAPS] = '{
      6'd0, 6'd7, 6'd13, 6'd22, 6'd27, 6'd31, 6'd33, 6'd33
   };

   localparam logic [STOP_IDX_W-1:0] MAP_LAST [NUM_MAPS] = '{
      6'd6, 6'd12, 6'd21, 6'd26, 6'd30, 6'd32, 6'd34, 6'd34
   };

   function automatic span_type span_code(input logic [POS_W-1:0] diff);
      span_type code;
      case (diff)
         10'd125: code = SPAN_125;
         10'd200: code = SPAN_200;
         10'd250: code = SPAN_250;
         10'd333: code = SPAN_333;
         10'd334: code = SPAN_334;
         default: code = SPAN_1000;
      endcase
      return code;
   endfunction

   function automatic logic [POS_W-1:0] span_value(input span_type code);
      logic [POS_W-1:0] value;
      case (code)
         SPAN_125: value = 10'd125;
         SPAN_200: value = 10'd200;
         SPAN_250: value = 10'd250;
         SPAN_333: value = 10'd333;
         SPAN_334: value = 10'd334;
         default:  value = 10'd1000;
      endcase
      return value;
   endfunction

   function automatic logic [RECIP_W-1:0] span_recip(input span_type code);
      logic [RECIP_W-1:0] value;
      case (code)
         SPAN_125: value = RECIP_125;
         SPAN_200: value = RECIP_200;
         SPAN_250: value = RECIP_250;
         SPAN_333: value = RECIP_333;
         SPAN_334: value = RECIP_334;
         default:  value = RECIP_1000;
      endcase
      return value;
   endfunction

endpackage

// File: sv/cms_lerp_chan.sv
`include "colormap_sampler_defines.svh"

module cms_lerp_chan #(
   parameter int FRACTION_BITS = cms_pkg::FRACTION_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cms_pkg::cms_adv_type                   adv,
   input  logic [FRACTION_BITS+9:0]               num,
   input  logic [cms_pkg::CH_W-1:0]               ca,
   input  logic signed [cms_pkg::CH_W:0]          dc,
   input  cms_pkg::span_type                      span,
   input  logic                                   is_hsv,
   input  logic [cms_pkg::CH_W-1:0]               hsv_val,
   output logic [cms_pkg::CH_W-1:0]               chan
);
   import cms_pkg::*;

   localparam int T_W   = FRACTION_BITS + 20;

   logic signed [T_W-1:0] dc_ext;
   logic signed [T_W-1:0] num_ext;
   logic signed [T_W-1:0] bias;
   logic signed [T_W-1:0] t5_in;
   logic signed [T_W-1:0] t5_ff;
   logic [CH_W-1:0]       ca5_ff;
   span_type              span5_ff;
   logic                  hsv5_ff;
   logic [CH_W-1:0]       hsvval5_ff;

   logic signed [T_W-1:0] q_s;
   logic signed [T_W-1:0] qp_full;
   logic [QP_W-1:0]       qp6_in;
   logic [PROD_W-1:0]     prod;
   logic [EST_W-1:0]      est6_in;
   logic [QP_W-1:0]       qp6_ff;
   logic [EST_W-1:0]      est6_ff;
   logic [CH_W-1:0]       ca6_ff;
   span_type              span6_ff;
   logic                  hsv6_ff;
   logic [CH_W-1:0]       hsvval6_ff;

   logic [REM_W-1:0]      back;
   logic [REM_W-1:0]      rem;
   logic [REM_W-1:0]      span6_ext;
   logic                  corr;
   logic [CH_W-1:0]       chan_in;
   logic [CH_W-1:0]       chan_ff;

   always_comb begin
      dc_ext  = T_W'(dc);
      num_ext = T_W'({1'b0, num});
      bias    = T_W'(span_value(span)) <<< (FRACTION_BITS - 1);
      t5_in   = dc_ext * num_ext + bias;
   end

   always_ff @(posedge clock) begin
      if (adv.s5_load) begin
         t5_ff      <= t5_in;
         ca5_ff     <= ca;
         span5_ff   <= span;
         hsv5_ff    <= is_hsv;
         hsvval5_ff <= hsv_val;
      end
   end

   always_comb begin
      q_s     = t5_ff >>> FRACTION_BITS;
      qp_full = q_s + T_W'({span_value(span5_ff), 8'b0});
      qp6_in  = qp_full[QP_W-1:0];
      prod    = PROD_W'(qp6_in) * PROD_W'(span_recip(span5_ff));
      est6_in = prod[RECIP_SHIFT+EST_W-1:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (adv.s6_load) begin
         qp6_ff     <= qp6_in;
         est6_ff    <= est6_in;
         ca6_ff     <= ca5_ff;
         span6_ff   <= span5_ff;
         hsv6_ff    <= hsv5_ff;
         hsvval6_ff <= hsvval5_ff;
      end
   end

   always_comb begin
      span6_ext = REM_W'(span_value(span6_ff));
      back      = REM_W'(est6_ff) * span6_ext;
      rem       = REM_W'(qp6_ff) - back;
      corr      = (rem >= span6_ext);
      if (hsv6_ff) begin
         chan_in = hsvval6_ff;
      end else begin
         chan_in = ca6_ff + est6_ff[CH_W-1:0] + CH_W'(corr);
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s7_load) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

   `CMS_ASSERT_IMPLIES(a_quot_close, clock, reset, adv.s6_full && !hsv6_ff, (back <= REM_W'(qp6_ff)) && (rem < (span6_ext << 1)), "reciprocal quotient estimate is off by more than one")

endmodule

// File: sv/colormap_sampler.sv
// Colormap sampler: turns one scalar level into an 8-bit RGB color.
// The request channel (req_*) carries an 18-bit signed level with FRACTION_BITS
// fraction bits; it is clamped to the range zero to one before use.
// The response channel (rsp_*) returns red, green and blue for every item.
// The csr_* channel writes the 3-bit colormap select; it is always ready and
// should only be written while no item is in flight.
// Seven maps interpolate between constant color stops with round to nearest;
// map seven converts the level as a hue at full saturation and value.
// The datapath is a seven-stage pipeline: an accepted item moves through the
// stage registers one to seven in order, rsp_tvalid is the valid bit of the
// seventh stage, and one item per cycle is sustained while rsp_tready is high.
// The stage count is set by the stop search and the divide by the segment
// span, done as a reciprocal multiply followed by a one-step correction.
// Each stage has its own valid bit, so bubbles collapse while the receiver
// stalls and req_tready only drops once every stage holds an item.
// Reset empties the pipeline and selects the first map.
`include "colormap_sampler_defines.svh"

module colormap_sampler #(
   parameter int FRACTION_BITS = cms_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [17:0] level, [23:18] zero
   input  logic [cms_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [cms_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cms_pkg::SEL_W-1:0]     csr_data
);
   import cms_pkg::*;

   localparam int LV_W   = FRACTION_BITS + 1;
   localparam int EXT_W  = (FRACTION_BITS + 2 > LEVEL_W) ? FRACTION_BITS + 2 : LEVEL_W;
   localparam int SC_W   = FRACTION_BITS + 11;
   localparam int H_W    = FRACTION_BITS + 3;
   localparam int RISE_W = FRACTION_BITS + 9;
   localparam int NUM_W  = FRACTION_BITS + 10;
   localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1) << FRACTION_BITS;

   logic [SEL_W-1:0]      sel_ff;

   logic [7:1]            valid_ff;
   logic [7:1]            valid_in;
   logic [8:1]            stage_ready;
   cms_adv_type           adv;

   logic [LEVEL_W-1:0]    level;
   logic [EXT_W-1:0]      lvl_ext;
   logic [LV_W-1:0]       lv1_in;
   logic [LV_W-1:0]       lv1_ff;
   logic [SEL_W-1:0]      sel1_ff;

   logic [SC_W-1:0]       scaled2_in;
   logic [SC_W-1:0]       scaled2_ff;
   logic [H_W-1:0]        h2_in;
   logic [H_W-1:0]        h2_ff;
   logic [SEL_W-1:0]      sel2_ff;

   logic [RISE_W-1:0]     rise_sum;
   logic [CH_W-1:0]       rise;
   logic [CH_W-1:0]       fall;
   logic [2:0]            sector;
   logic [RGB_W-1:0]      hsv3_in;
   logic [STOP_IDX_W-1:0] first_idx;
   logic [STOP_IDX_W-1:0] last_idx;
   logic [STOP_IDX_W-1:0] cand;
   logic [STOP_IDX_W-1:0] b3_in;
   logic                  found;
   logic [STOP_IDX_W-1:0] b3_ff;
   logic [SC_W-1:0]       scaled3_ff;
   logic [RGB_W-1:0]      hsv3_ff;
   logic [SEL_W-1:0]      sel3_ff;

   logic [STOP_IDX_W-1:0] a_idx;
   logic [POS_W-1:0]      pos_a;
   logic [POS_W-1:0]      pos_b;
   logic [RGB_W-1:0]      rgb_a;
   logic [RGB_W-1:0]      rgb_b;
   logic [SC_W-1:0]       num_full;
   logic [NUM_W-1:0]      num4_ff;
   logic [RGB_W-1:0]      ca4_ff;
   logic [RGB_W-1:0]      cb4_ff;
   span_type              span4_in;
   span_type              span4_ff;
   logic                  hsv4_flag_ff;
   logic [RGB_W-1:0]      hsv4_ff;
   logic signed [CH_W:0]  dc4 [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (csr_valid) begin
         sel_ff <= csr_data;
      end
   end

   always_comb begin
      stage_ready[8] = rsp_tready;
      for (int i = 7; i >= 1; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      valid_in = (stage_ready[7:1] & {valid_ff[6:1], req_tvalid})
               | (~stage_ready[7:1] & valid_ff);
      adv.s5_load = stage_ready[5];
      adv.s6_load = stage_ready[6];
      adv.s7_load = stage_ready[7];
      adv.s6_full = valid_ff[6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ready[1];
   assign rsp_tvalid = valid_ff[7];

   always_comb begin
      level   = req_tdata[LEVEL_W-1:0];
      lvl_ext = EXT_W'($signed(level));
      if (level[LEVEL_W-1]) begin
         lv1_in = '0;
      end else if (lvl_ext > ONE_EXT) begin
         lv1_in = ONE_EXT[LV_W-1:0];
      end else begin
         lv1_in = lvl_ext[LV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         lv1_ff  <= lv1_in;
         sel1_ff <= sel_ff;
      end
   end

   assign scaled2_in = SC_W'(lv1_ff) * SC_W'(1000);
   assign h2_in      = H_W'(lv1_ff) * H_W'(6);

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         scaled2_ff <= scaled2_in;
         h2_ff      <= h2_in;
         sel2_ff    <= sel1_ff;
      end
   end

   always_comb begin
      rise_sum = RISE_W'(h2_ff[FRACTION_BITS-1:0]) * RISE_W'(255)
               + (RISE_W'(1) << (FRACTION_BITS - 1));
      rise     = rise_sum[FRACTION_BITS+CH_W-1:FRACTION_BITS];
      fall     = 8'd255 - rise;
      sector   = h2_ff[FRACTION_BITS+2:FRACTION_BITS];
      case (sector)
         3'd0:    hsv3_in = {8'd0, rise, 8'd255};
         3'd1:    hsv3_in = {8'd0, 8'd255, fall};
         3'd2:    hsv3_in = {rise, 8'd255, 8'd0};
         3'd3:    hsv3_in = {8'd255, fall, 8'd0};
         3'd4:    hsv3_in = {8'd255, 8'd0, rise};
         3'd5:    hsv3_in = {fall, 8'd0, 8'd255};
         default: hsv3_in = {8'd0, 8'd0, 8'd255};
      endcase
   end

   always_comb begin
      first_idx = MAP_FIRST[sel2_ff];
      last_idx  = MAP_LAST[sel2_ff];
      b3_in     = last_idx;
      found     = 1'b0;
      cand      = last_idx;
      for (int k = 0; k < MAX_SEGS; k++) begin
         cand = first_idx + STOP_IDX_W'(k + 1);
         if (cand > last_idx) begin
            cand = last_idx;
         end
         if (!found && (scaled2_ff <= (SC_W'(STOP_POS[cand]) << FRACTION_BITS))) begin
            b3_in = cand;
            found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         b3_ff      <= b3_in;
         scaled3_ff <= scaled2_ff;
         hsv3_ff    <= hsv3_in;
         sel3_ff    <= sel2_ff;
      end
   end

   always_comb begin
      a_idx     = b3_ff - STOP_IDX_W'(1);
      pos_a     = STOP_POS[a_idx];
      pos_b     = STOP_POS[b3_ff];
      rgb_a     = STOP_RGB[a_idx];
      rgb_b     = STOP_RGB[b3_ff];
      num_full  = scaled3_ff - (SC_W'(pos_a) << FRACTION_BITS);
      span4_in  = span_code(pos_b - pos_a);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         num4_ff      <= num_full[NUM_W-1:0];
         ca4_ff       <= rgb_a;
         cb4_ff       <= rgb_b;
         span4_ff     <= span4_in;
         hsv4_flag_ff <= (sel3_ff == SEL_HSV);
         hsv4_ff      <= hsv3_ff;
      end
   end

   // Stop colors are stored as {red, green, blue}; hue colors as {blue, green, red}.
   for (genvar c = 0; c < 3; c++) begin : g_chan
      assign dc4[c] = $signed({1'b0, cb4_ff[RGB_W-1-c*CH_W -: CH_W]})
                    - $signed({1'b0, ca4_ff[RGB_W-1-c*CH_W -: CH_W]});

      cms_lerp_chan #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_chan (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .num     (num4_ff),
         .ca      (ca4_ff[RGB_W-1-c*CH_W -: CH_W]),
         .dc      (dc4[c]),
         .span    (span4_ff),
         .is_hsv  (hsv4_flag_ff),
         .hsv_val (hsv4_ff[c*CH_W +: CH_W]),
         .chan    (rsp_tdata[c*CH_W +: CH_W])
      );
   end

   `CMS_ASSERT_IMPLIES(a_full_stall, clock, reset, (&valid_ff) && !rsp_tready, !req_tready, "input taken while every stage is full and stalled")
   `CMS_ASSERT_IMPLIES(a_seg_range, clock, reset, valid_ff[3] && (sel3_ff != SEL_HSV), (b3_ff > MAP_FIRST[sel3_ff]) && (b3_ff <= MAP_LAST[sel3_ff]), "segment end stop lies outside the selected map")
   `CMS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, valid_ff == '0, "pipeline not empty after reset")
   `CMS_ASSERT_NEXT(a_stage_hold, clock, reset, valid_ff[4] && !stage_ready[5], valid_ff[4], "blocked item lost from the fourth stage")

endmodule

// File: sim/cms_color_checker.sv
module cms_color_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [cms_pkg::REQ_W-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [cms_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [cms_pkg::SEL_W-1:0] csr_data,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import cms_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } rgb_type;

   localparam longint ONE = longint'(1) <<< FRACTION_BITS_DEF;

   // Stop positions are in thousandths of the full range, colors are 24'hRRGGBB.
   localparam int STOP_AT [35] = '{
      0, 125, 375, 500, 625, 875, 1000,
      0, 200, 400, 600, 800, 1000,
      0, 125, 250, 375, 500, 625, 750, 875, 1000,
      0, 250, 500, 750, 1000,
      0, 333, 666, 1000,
      0, 1000,
      0, 1000
   };
   localparam logic [23:0] STOP_COLOR [35] = '{
      24'h000080, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000, 24'h800000,
      24'h352A87, 24'h1263DF, 24'h04A3BB, 24'h51BC78, 24'hE5B841, 24'hF9FB0E,
      24'h30123B, 24'h466BE3, 24'h29BFEC, 24'h28E598, 24'h91F642, 24'hE2DE35,
      24'hF99627, 24'hDB421A, 24'h7A0B04,
      24'h440154, 24'h3B528B, 24'h21918C, 24'h5EC961, 24'hFDE725,
      24'h000000, 24'hE60000, 24'hFFE600, 24'hFFFFFF,
      24'h00FFFF, 24'hFF00FF,
      24'h000000, 24'hFFFFFF
   };
   localparam int MAP_BASE  [7] = '{0, 7, 13, 22, 27, 31, 33};
   localparam int MAP_STOPS [7] = '{7, 6, 9, 5, 4, 2, 2};

   logic [SEL_W-1:0] map_sel;
   rgb_type          colors_due [$];
   rgb_type          want;
   rgb_type          got;

   function automatic logic [CH_W-1:0] blend_channel(input longint ca, input longint cb,
                                                     input longint num, input longint den);
      longint acc;
      acc = ca * den + (cb - ca) * num + den / 2;
      return CH_W'(acc / den);
   endfunction

   function automatic rgb_type sample_colormap(input logic [SEL_W-1:0] map,
                                               input logic [LEVEL_W-1:0] raw);
      longint lv, h, f, rise, fall, sector, scaled, num, den, pos_a, pos_b;
      logic [23:0] ca, cb;
      rgb_type c;
      int base, i;
      lv = longint'(signed'(raw));
      if (lv < 0) lv = 0;
      if (lv > ONE) lv = ONE;
      c = '0;
      if (map == SEL_HSV) begin
         h = 6 * lv;
         sector = h >>> FRACTION_BITS_DEF;
         f = h & (ONE - 1);
         rise = (255 * f + ONE / 2) / ONE;
         fall = 255 - rise;
         // A level of exactly one wraps around to hue zero.
         if (sector >= 6) sector = 0;
         case (sector)
            0: c = '{red: 8'd255, green: CH_W'(rise), blue: 8'd0};
            1: c = '{red: CH_W'(fall), green: 8'd255, blue: 8'd0};
            2: c = '{red: 8'd0, green: 8'd255, blue: CH_W'(rise)};
            3: c = '{red: 8'd0, green: CH_W'(fall), blue: 8'd255};
            4: c = '{red: CH_W'(rise), green: 8'd0, blue: 8'd255};
            default: c = '{red: 8'd255, green: 8'd0, blue: CH_W'(fall)};
         endcase
         return c;
      end
      base = MAP_BASE[map];
      scaled = lv * 1000;
      for (i = 1; i < MAP_STOPS[map]; i++) begin
         pos_a = STOP_AT[base + i - 1];
         pos_b = STOP_AT[base + i];
         if (scaled <= (pos_b <<< FRACTION_BITS_DEF)) begin
            num = scaled - (pos_a <<< FRACTION_BITS_DEF);
            den = (pos_b - pos_a) <<< FRACTION_BITS_DEF;
            if (num < 0) num = 0;
            if (num > den) num = den;
            ca = STOP_COLOR[base + i - 1];
            cb = STOP_COLOR[base + i];
            c.red   = blend_channel(ca[23:16], cb[23:16], num, den);
            c.green = blend_channel(ca[15:8], cb[15:8], num, den);
            c.blue  = blend_channel(ca[7:0], cb[7:0], num, den);
            return c;
         end
      end
      cb = STOP_COLOR[base + MAP_STOPS[map] - 1];
      c = '{red: cb[23:16], green: cb[15:8], blue: cb[7:0]};
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int seen, input int wanted);
      fail_count++;
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, seen, wanted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         map_sel = '0;
         colors_due.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            map_sel = csr_data;
         if (req_tvalid && req_tready)
            colors_due.push_back(sample_colormap(map_sel, req_tdata[LEVEL_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rgb_type'(rsp_tdata);
            if (colors_due.size() == 0) begin
               report_mismatch("color with no level pending", int'(rsp_tdata), 0);
            end else begin
               want = colors_due.pop_front();
               if (got.red !== want.red)
                  report_mismatch("red", int'(got.red), int'(want.red));
               if (got.green !== want.green)
                  report_mismatch("green", int'(got.green), int'(want.green));
               if (got.blue !== want.blue)
                  report_mismatch("blue", int'(got.blue), int'(want.blue));
            end
         end
      end
      pending = colors_due.size();
   end

endmodule

// File: sim/tb_colormap_sampler.sv
module tb_colormap_sampler;
   timeunit 1ns;
   timeprecision 1ps;

   import cms_pkg::*;

   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 86;
   localparam int LAST_PHASE       = 11;
   localparam int STEADY_PHASE     = 4;
   localparam int IDLE_PERCENT     = 29;
   localparam int SETTLE_CYCLES    = 20;
   localparam int NUM_CORNERS      = 8;

   localparam logic [LEVEL_W-1:0] DIRECTED_LEVELS [22] = '{
      18'h20000, 18'h1FFFF, 18'h3FFFF, 18'd0, 18'd1, 18'd65535, 18'd65536, 18'd65537,
      18'd8192, 18'd16384, 18'd24576, 18'd32768, 18'd40960, 18'd57344,
      18'd13107, 18'd13108, 18'd21823, 18'd21824, 18'd43647,
      18'd10922, 18'd10923, 18'd54613
   };

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [SEL_W-1:0] csr_data   = '0;
   logic             steady     = 1'b0;
   int               fail_count;
   int               pending;

   colormap_sampler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   cms_color_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Most levels sit inside zero to one; some land next to color stops and hue sector edges.
   function automatic logic [LEVEL_W-1:0] pick_level();
      int roll, pos, anchor;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return LEVEL_W'($urandom);
      if (roll < 20)
         return DIRECTED_LEVELS[$urandom_range(0, NUM_CORNERS - 1)];
      if (roll < 40) begin
         case ($urandom_range(0, 3))
            0: pos = 125 * int'($urandom_range(0, 8));
            1: pos = 200 * int'($urandom_range(0, 5));
            2: pos = 333 * int'($urandom_range(0, 3));
            default: pos = -1;
         endcase
         if (pos < 0)
            anchor = (65536 * int'($urandom_range(0, 6))) / 6;
         else
            anchor = (pos * 65536) / 1000;
         return LEVEL_W'(anchor + int'($urandom_range(0, 4)) - 2);
      end
      return LEVEL_W'($urandom_range(0, 65536));
   endfunction

   task automatic push_level(input logic [LEVEL_W-1:0] level);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(level);
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_select(input logic [SEL_W-1:0] sel);
      csr_valid <= 1'b1;
      csr_data  <= sel;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_LEVELS[i])
         push_level(DIRECTED_LEVELS[i]);
      repeat (RANDOM_PER_PHASE) push_level(pick_level());
      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         drain();
         if (phase <= NUM_MAPS)
            write_select(SEL_HSV - SEL_W'(phase - 1));
         else
            write_select(SEL_W'($urandom_range(0, SEL_HSV)));
         steady <= (phase == STEADY_PHASE);
         repeat (RANDOM_PER_PHASE) push_level(pick_level());
      end
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/cms_pkg.sv
sv/cms_lerp_chan.sv
sv/colormap_sampler.sv
sim/cms_color_checker.sv
sim/tb_colormap_sampler.sv
